[sv/lsf_pkg.sv]
package lsf_pkg;

    localparam int MAX_PATTERN = 48;
    localparam int MAX_LINE    = 256;

    localparam int PATTERN_WORDS = 6;
    localparam int CFG_WIDTH     = 64;
    localparam int CFG_ADDR_W    = 6;
    localparam int POS_W         = 9;
    localparam int LEN_W         = 6;

    localparam logic [7:0] CR_BYTE    = 8'd13;
    localparam logic [7:0] NUL_BYTE   = 8'd0;
    localparam logic [7:0] CASE_DELTA = 8'd32;

    // Register indexes, taken from paddr bits [5:3].
    localparam logic [2:0] REG_PATTERN_LAST = 3'd5;
    localparam logic [2:0] REG_LENGTH       = 3'd6;

    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_MATCH    = 2'd1;
    localparam logic [1:0] ST_UNMATCHED = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic load;
        logic clear;
    } lsf_cell_ctrl_t;

    typedef struct packed {
        logic [7:0] match_offset;
        logic [1:0] status;
    } lsf_result_t;

    function automatic logic byte_matches(input logic [7:0] c, input logic [7:0] p);
        logic [7:0] folded;
        folded = p - CASE_DELTA;
        return (c == p) || (c == folded);
    endfunction

endpackage

[sv/lsf_cell.sv]
module lsf_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lsf_pkg::lsf_cell_ctrl_t ctrl,
    input  logic [7:0]             ch,
    input  logic [7:0]             pattern_byte,
    input  logic                   active,
    input  logic                   prev_bit,
    output logic                   bit_next,
    output logic                   bit_reg
);

    assign bit_next = active && prev_bit && lsf_pkg::byte_matches(ch, pattern_byte);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg <= 1'b0;
        end else if (ctrl.load) begin
            bit_reg <= ctrl.clear ? 1'b0 : bit_next;
        end
    end

endmodule

[sv/line_substring_finder_top.sv]
// The result for an accepted input beat is registered in the output stage before it appears on m_tvalid.
// Throughput: one beat per cycle while s_tready is high; the 48-cell shift-and chain advances one step per beat.
// A two-entry output stage (output register plus skid) keeps s_tready high while one
// result waits; s_tready drops only when both entries are full.
// Reset (aresetn low, synchronous): clears the match vector, position, skip and the
// output stage, marks the block idle until a line starts, pattern to zero, length to 1.
module line_substring_finder_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,  // ch [7:0], skip [15:8]
    input  logic                              s_tuser,  // line_first
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,  // status [1:0], match_offset [9:2]
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lsf_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [lsf_pkg::CFG_WIDTH-1:0]     pwdata,
    output logic [lsf_pkg::CFG_WIDTH-1:0]     prdata,
    output logic                              pready
);

    localparam int PAT_BITS = lsf_pkg::PATTERN_WORDS * lsf_pkg::CFG_WIDTH;

    // Configuration registers.
    logic [PAT_BITS-1:0]          pattern_reg;
    logic [lsf_pkg::LEN_W-1:0]    length_reg;
    logic [2:0]                   cfg_idx;
    logic                         cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            length_reg  <= lsf_pkg::LEN_W'(1);
        end else if (cfg_wr) begin
            if (cfg_idx <= lsf_pkg::REG_PATTERN_LAST) begin
                pattern_reg[cfg_idx*lsf_pkg::CFG_WIDTH +: lsf_pkg::CFG_WIDTH] <= pwdata;
            end else if (cfg_idx == lsf_pkg::REG_LENGTH) begin
                length_reg <= pwdata[lsf_pkg::LEN_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (cfg_idx <= lsf_pkg::REG_PATTERN_LAST) begin
            prdata = pattern_reg[cfg_idx*lsf_pkg::CFG_WIDTH +: lsf_pkg::CFG_WIDTH];
        end else if (cfg_idx == lsf_pkg::REG_LENGTH) begin
            prdata = {{(lsf_pkg::CFG_WIDTH-lsf_pkg::LEN_W){1'b0}}, length_reg};
        end
    end

    // Out-of-range lengths fold into 1..MAX_PATTERN.
    logic [lsf_pkg::LEN_W-1:0] len_eff;
    logic [lsf_pkg::LEN_W-1:0] len_last;

    always_comb begin
        len_eff = length_reg;
        if (length_reg == '0) begin
            len_eff = lsf_pkg::LEN_W'(1);
        end else if (length_reg > lsf_pkg::LEN_W'(lsf_pkg::MAX_PATTERN)) begin
            len_eff = lsf_pkg::LEN_W'(lsf_pkg::MAX_PATTERN);
        end
    end
    assign len_last = len_eff - lsf_pkg::LEN_W'(1);

    // Line state.
    logic [lsf_pkg::POS_W-1:0] position_reg, position_next;
    logic [7:0]                skip_reg, skip_next;
    logic                      resolved_reg, resolved_next;

    logic [7:0]                in_ch, in_skip;
    logic                      in_first, accept;

    assign in_ch    = s_tdata[7:0];
    assign in_skip  = s_tdata[15:8];
    assign in_first = s_tuser;
    assign accept   = s_tvalid && s_tready;

    logic [lsf_pkg::POS_W-1:0] pos_eff;
    logic [7:0]                skip_eff;
    logic                      resolved_eff, line_end, overflow, start_ok, hit;

    assign pos_eff      = in_first ? '0 : position_reg;
    assign skip_eff     = in_first ? in_skip : skip_reg;
    assign resolved_eff = in_first ? 1'b0 : resolved_reg;
    assign line_end     = (in_ch == lsf_pkg::CR_BYTE) || (in_ch == lsf_pkg::NUL_BYTE);
    assign overflow     = pos_eff >= lsf_pkg::POS_W'(lsf_pkg::MAX_LINE);
    assign start_ok     = pos_eff >= {1'b0, skip_eff};

    // Cell chain.
    logic [lsf_pkg::MAX_PATTERN-1:0] bits_reg, bits_next, active;
    lsf_pkg::lsf_cell_ctrl_t         cell_ctrl;

    assign hit = !resolved_eff && !line_end && !overflow && bits_next[len_last];

    assign cell_ctrl.load  = accept;
    assign cell_ctrl.clear = resolved_eff || line_end || overflow || hit;

    genvar gi;
    generate
        for (gi = 0; gi < lsf_pkg::MAX_PATTERN; gi++) begin : g_cell
            logic prev;
            if (gi == 0) begin : g_head
                // The head cell's neighbor is the skip window: a match may start here.
                assign prev = start_ok;
            end else begin : g_body
                // A new line starts from an empty vector, so the neighbor's old bit is ignored.
                assign prev = bits_reg[gi-1] && !in_first;
            end
            assign active[gi] = lsf_pkg::LEN_W'(gi) < len_eff;

            lsf_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (cell_ctrl),
                .ch          (in_ch),
                .pattern_byte(pattern_reg[gi*8 +: 8]),
                .active      (active[gi]),
                .prev_bit    (prev),
                .bit_next    (bits_next[gi]),
                .bit_reg     (bits_reg[gi])
            );
        end
    endgenerate

    // Result for the beat at the input.
    lsf_pkg::lsf_result_t res;
    logic [lsf_pkg::POS_W-1:0] start_pos;

    assign start_pos = pos_eff + lsf_pkg::POS_W'(1) - {3'b000, len_eff};

    always_comb begin
        res.status       = lsf_pkg::ST_NONE;
        res.match_offset = '0;
        if (!resolved_eff) begin
            if (line_end) begin
                res.status = lsf_pkg::ST_UNMATCHED;
            end else if (overflow) begin
                res.status = lsf_pkg::ST_OVERFLOW;
            end else if (hit) begin
                res.status       = lsf_pkg::ST_MATCH;
                res.match_offset = start_pos[7:0];
            end
        end
    end

    always_comb begin
        position_next = position_reg;
        skip_next     = skip_reg;
        resolved_next = resolved_reg;
        if (accept) begin
            position_next = pos_eff;
            skip_next     = skip_eff;
            resolved_next = resolved_eff;
            if (!resolved_eff) begin
                if (line_end || overflow || hit) begin
                    resolved_next = 1'b1;
                end else begin
                    position_next = pos_eff + lsf_pkg::POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            skip_reg     <= '0;
            resolved_reg <= 1'b1;
        end else begin
            position_reg <= position_next;
            skip_reg     <= skip_next;
            resolved_reg <= resolved_next;
        end
    end

    // Output register with a skid entry behind it.
    lsf_pkg::lsf_result_t main_reg, main_next, skid_reg, skid_next;
    logic                 main_valid_reg, main_valid_next, skid_valid_reg, skid_valid_next;
    logic                 pop;

    assign pop      = m_tvalid && m_tready;
    assign s_tready = !skid_valid_reg;

    always_comb begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = 1'b0;
            end
        end
        if (accept) begin
            if (main_valid_next) begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end else begin
                main_next       = res;
                main_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {6'b000000, main_reg.match_offset, main_reg.status};

    // A resolving beat leaves the line resolved and the vector empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (res.status != lsf_pkg::ST_NONE) |=> resolved_reg && (bits_reg == '0))
        else $error("line not resolved after a final status");

    // While a line is resolved, no partial match survives.
    assert property (@(posedge aclk) disable iff (!aresetn)
        resolved_reg |-> (bits_reg == '0))
        else $error("partial match bits set on a resolved line");

    // The skid entry is only ever filled behind a full output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid with empty output register");

    // Position never runs past the overflow point.
    assert property (@(posedge aclk) disable iff (!aresetn)
        position_reg <= lsf_pkg::POS_W'(lsf_pkg::MAX_LINE))
        else $error("position beyond line limit");

endmodule

[bench/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_PATTERN_FIRST = 3'd0;
    localparam logic [2:0] REG_SPARE         = 3'd7;
    localparam int GAP_MAX      = 18;
    localparam int HOLD_CYCLES  = 150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 300;
    localparam int RESET_CYCLES = 12;
    localparam logic [7:0] FILL_BYTE = 8'h2E;

    typedef enum {ALPHA_SMALL, ALPHA_ANY, ALPHA_EDGE, ALPHA_LETTERS} alphabet_t;

    typedef struct {
        logic [7:0] ch;
        logic       first;
        logic [7:0] skip;
    } line_beat_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [15:0]                    s_tdata  = '0;  // ch [7:0], skip [15:8]
    logic                           s_tuser  = 1'b0;  // line_first
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [15:0]                    m_tdata;  // status [1:0], match_offset [9:2]
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [lsf_pkg::CFG_ADDR_W-1:0] paddr    = '0;
    logic [lsf_pkg::CFG_WIDTH-1:0]  pwdata   = '0;
    logic [lsf_pkg::CFG_WIDTH-1:0]  prdata;
    logic                           pready;

    line_substring_finder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    // Scanner state as the testbench sees it.
    logic [63:0]                     pat_words [lsf_pkg::PATTERN_WORDS];
    logic [lsf_pkg::LEN_W-1:0]       pat_len;
    logic [lsf_pkg::MAX_PATTERN-1:0] run_bits;
    logic [lsf_pkg::POS_W-1:0]       line_pos;
    logic [7:0]                      skip_from;
    logic                            line_done;

    line_beat_t           send_q [$];
    lsf_pkg::lsf_result_t pending_results [$];

    int  mismatches   = 0;
    int  results_seen = 0;
    int  queued_beats = 0;
    int  cycle_count  = 0;
    int  tx_wait      = 0;
    int  rx_wait      = 0;
    int  hold_left    = 0;
    logic hold_start  = 1'b0;
    bit  tx_idle_on   = 1'b0;
    bit  rx_idle_on   = 1'b0;

    function automatic logic [7:0] pat_byte(int unsigned i);
        return pat_words[i / 8][(i % 8) * 8 +: 8];
    endfunction

    function automatic int unsigned active_len();
        if (pat_len == 0)
            return 1;
        if (pat_len > lsf_pkg::MAX_PATTERN)
            return lsf_pkg::MAX_PATTERN;
        return 32'(pat_len);
    endfunction

    // A line byte hits a pattern byte when it equals it or sits 32 below it, mod 256.
    function automatic logic folds_to(logic [7:0] c, logic [7:0] p);
        return (c == p) || (8'(c + lsf_pkg::CASE_DELTA) == p);
    endfunction

    function automatic lsf_pkg::lsf_result_t scan_byte(logic [7:0] ch, logic first,
                                                       logic [7:0] skip);
        lsf_pkg::lsf_result_t            res;
        int unsigned                     len;
        int unsigned                     i;
        logic [lsf_pkg::MAX_PATTERN-1:0] nxt;
        res = '0;
        len = active_len();
        if (first) begin
            run_bits  = '0;
            line_pos  = '0;
            skip_from = skip;
            line_done = 1'b0;
        end
        if (line_done)
            return res;
        if (ch == lsf_pkg::CR_BYTE || ch == lsf_pkg::NUL_BYTE) begin
            res.status = lsf_pkg::ST_UNMATCHED;
            line_done  = 1'b1;
            run_bits   = '0;
            return res;
        end
        if (line_pos >= lsf_pkg::MAX_LINE) begin
            res.status = lsf_pkg::ST_OVERFLOW;
            line_done  = 1'b1;
            run_bits   = '0;
            return res;
        end
        nxt = '0;
        nxt[0] = (line_pos >= skip_from) && folds_to(ch, pat_byte(0));
        for (i = 1; i < len; i++)
            nxt[i] = run_bits[i - 1] && folds_to(ch, pat_byte(i));
        run_bits = nxt;
        if (run_bits[len - 1]) begin
            res.status       = lsf_pkg::ST_MATCH;
            res.match_offset = 8'(line_pos + 1 - len);
            line_done        = 1'b1;
            run_bits         = '0;
            return res;
        end
        line_pos = line_pos + 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("[%0t] result %0d: %s is %0d, expected %0d", $time, results_seen, what, got,
                 want);
    endtask

    // Input side: one beat per handshake, with a drawn gap after each beat when tx_idle_on is set.
    always @(posedge aclk) begin : beat_source
        line_beat_t nb;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (s_tvalid && s_tready)
                pending_results.push_back(scan_byte(s_tdata[7:0], s_tuser, s_tdata[15:8]));
            if (!s_tvalid || s_tready) begin
                if (tx_wait != 0) begin
                    tx_wait--;
                    s_tvalid <= 1'b0;
                end else if (send_q.size() != 0) begin
                    nb = send_q.pop_front();
                    s_tdata  <= {nb.skip, nb.ch};
                    s_tuser  <= nb.first;
                    s_tvalid <= 1'b1;
                    tx_wait = tx_idle_on ? $urandom_range(0, GAP_MAX) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            hold_left <= 0;
        else if (hold_start)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Result side: compare each beat with the oldest expectation.
    always @(posedge aclk) begin : result_sink
        lsf_pkg::lsf_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected beat, status", m_tdata[1:0], lsf_pkg::ST_NONE);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata[1:0] != want.status)
                        report_mismatch("status", m_tdata[1:0], want.status);
                    if (m_tdata[9:2] != want.match_offset)
                        report_mismatch("match_offset", m_tdata[9:2], want.match_offset);
                    if (m_tdata[15:10] != '0)
                        report_mismatch("padding", m_tdata[15:10], 0);
                end
                results_seen++;
                rx_wait = rx_idle_on ? $urandom_range(0, GAP_MAX) : 0;
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
            m_tready <= (rx_wait == 0) && (hold_left == 0);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("line_substring_finder_top test failed");
            $finish;
        end
    end

    task automatic reset_scanner();
        int k;
        for (k = 0; k < lsf_pkg::PATTERN_WORDS; k++)
            pat_words[k] = '0;
        pat_len   = lsf_pkg::LEN_W'(1);
        run_bits  = '0;
        line_pos  = '0;
        skip_from = '0;
        line_done = 1'b1;
    endtask

    task automatic put(logic [7:0] ch, logic first, logic [7:0] skip);
        line_beat_t nb;
        nb.ch    = ch;
        nb.first = first;
        nb.skip  = skip;
        send_q.push_back(nb);
        queued_beats++;
    endtask

    task automatic wait_idle();
        do
            @(negedge aclk);
        while (send_q.size() != 0 || s_tvalid || pending_results.size() != 0);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [63:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx <= lsf_pkg::REG_PATTERN_LAST)
            pat_words[idx] = value;
        else if (idx == lsf_pkg::REG_LENGTH)
            pat_len = value[lsf_pkg::LEN_W-1:0];
    endtask

    function automatic logic [7:0] case_variant(logic [7:0] p);
        return $urandom_range(0, 1) ? p : 8'(p - lsf_pkg::CASE_DELTA);
    endfunction

    function automatic logic [7:0] line_char(int unsigned eff);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return case_variant(pat_byte($urandom_range(0, eff - 1)));
        if (r < 98)
            return 8'($urandom_range(1, 255));
        return $urandom_range(0, 1) ? lsf_pkg::CR_BYTE : lsf_pkg::NUL_BYTE;
    endfunction

    // Mostly well-formed lines: random lead-in, often a full copy of the pattern, an end byte,
    // then a few bytes that arrive after the line is settled.
    task automatic queue_line(int unsigned eff);
        int unsigned prefix, suffix, tail, r, i;
        logic [7:0]  skip;
        prefix = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
        r = $urandom_range(0, 99);
        if (r < 60)
            skip = 8'($urandom_range(0, prefix + 2));
        else if (r < 80)
            skip = 8'h00;
        else
            skip = 8'($urandom_range(0, 255));
        put(line_char(eff), 1'b1, skip);
        for (i = 0; i < prefix; i++)
            put(line_char(eff), 1'b0, 8'($urandom));
        if ($urandom_range(0, 9) < 7) begin
            for (i = 0; i < eff; i++) begin
                if ($urandom_range(0, 15) == 0)
                    put(8'($urandom), 1'b0, 8'($urandom));
                else
                    put(case_variant(pat_byte(i)), 1'b0, 8'($urandom));
            end
        end
        suffix = $urandom_range(0, 8);
        for (i = 0; i < suffix; i++)
            put(line_char(eff), 1'b0, 8'($urandom));
        if ($urandom_range(0, 4) != 0)
            put($urandom_range(0, 1) ? lsf_pkg::CR_BYTE : lsf_pkg::NUL_BYTE, 1'b0,
                8'($urandom));
        tail = $urandom_range(0, 2);
        for (i = 0; i < tail; i++)
            put(8'($urandom), 1'b0, 8'($urandom));
    endtask

    initial begin : stimulus
        int                        phase, k, b, i, random_items;
        int unsigned               target, r;
        logic [63:0]               word;
        logic [7:0]                pb;
        alphabet_t                 alpha;
        logic [lsf_pkg::LEN_W-1:0] new_len;

        random_items = 0;
        reset_scanner();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // After reset the pattern is a single zero byte, which only line byte 224 can hit.
        @(negedge aclk);
        put(8'h41, 1'b0, 8'h00);
        put(8'hE0, 1'b1, 8'h00);
        put(8'hE0, 1'b0, 8'h00);
        put(lsf_pkg::NUL_BYTE, 1'b1, 8'hFF);
        put(lsf_pkg::CR_BYTE, 1'b1, 8'h00);
        put(8'hE0, 1'b1, 8'h02);
        put(8'hE0, 1'b0, 8'h00);
        put(8'hE0, 1'b0, 8'h00);
        put(8'hE0, 1'b1, 8'd200);
        put(8'hFF, 1'b0, 8'h00);
        put(lsf_pkg::CR_BYTE, 1'b0, 8'h00);
        wait_idle();

        // Folding across the wrap: 0x10 is also hit by 0xF0, 0xFF by 0xDF.
        cfg_write(REG_PATTERN_FIRST, 64'h0000_0000_00FF_1061);
        cfg_write(lsf_pkg::REG_LENGTH, 64'd3);
        cfg_write(REG_SPARE, {$urandom, $urandom});
        @(negedge aclk);
        put(8'h41, 1'b1, 8'h00);
        put(8'hF0, 1'b0, 8'h00);
        put(8'hDF, 1'b0, 8'h00);
        put(8'h61, 1'b1, 8'h00);
        put(8'h10, 1'b0, 8'h00);
        put(8'hFF, 1'b0, 8'h00);
        put(8'h61, 1'b1, 8'h01);
        put(8'h61, 1'b0, 8'h00);
        put(8'h10, 1'b0, 8'h00);
        put(8'hFF, 1'b0, 8'h00);
        wait_idle();

        for (phase = 0; random_items < RANDOM_ITEMS || phase <= 3; phase++) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);

            if (phase == 3) begin
                // Lines that run up to and past the end of the position range.
                cfg_write(REG_PATTERN_FIRST, 64'h0000_0000_007A_7978);
                for (k = 1; k < lsf_pkg::PATTERN_WORDS; k++)
                    cfg_write(REG_PATTERN_FIRST + 3'(k), 64'h0);
                cfg_write(lsf_pkg::REG_LENGTH, 64'd3);
                @(negedge aclk);
                put(FILL_BYTE, 1'b1, 8'd253);
                for (i = 1; i < 253; i++)
                    put(FILL_BYTE, 1'b0, 8'($urandom));
                put(8'h58, 1'b0, 8'($urandom));
                put(8'h79, 1'b0, 8'($urandom));
                put(8'h5A, 1'b0, 8'($urandom));
                put(FILL_BYTE, 1'b1, 8'h00);
                for (i = 1; i < 254; i++)
                    put(FILL_BYTE, 1'b0, 8'($urandom));
                put(8'h78, 1'b0, 8'($urandom));
                put(8'h59, 1'b0, 8'($urandom));
                put(8'h7A, 1'b0, 8'($urandom));
                put(FILL_BYTE, 1'b1, 8'h00);
                for (i = 1; i < 256; i++)
                    put(FILL_BYTE, 1'b0, 8'($urandom));
                put(lsf_pkg::CR_BYTE, 1'b0, 8'($urandom));
                wait_idle();
                continue;
            end

            case (phase)
                0: begin
                    alpha   = ALPHA_SMALL;
                    new_len = lsf_pkg::LEN_W'(lsf_pkg::MAX_PATTERN);
                end
                1: begin
                    alpha   = ALPHA_EDGE;
                    new_len = '1;
                end
                2: begin
                    alpha   = ALPHA_ANY;
                    new_len = '0;
                end
                default: begin
                    alpha = alphabet_t'($urandom_range(0, 3));
                    r = $urandom_range(0, 99);
                    if (r < 55)
                        new_len = lsf_pkg::LEN_W'($urandom_range(1, 6));
                    else if (r < 75)
                        new_len = lsf_pkg::LEN_W'($urandom_range(7, 16));
                    else if (r < 88)
                        new_len = lsf_pkg::LEN_W'($urandom_range(17, lsf_pkg::MAX_PATTERN));
                    else
                        new_len = $urandom_range(0, 1) ? '0 :
                                  lsf_pkg::LEN_W'($urandom_range(lsf_pkg::MAX_PATTERN, 63));
                end
            endcase

            for (k = 0; k < lsf_pkg::PATTERN_WORDS; k++) begin
                word = '0;
                for (b = 0; b < 8; b++) begin
                    case (alpha)
                        ALPHA_SMALL:   pb = 8'h61 + 8'($urandom_range(0, 3));
                        ALPHA_ANY:     pb = 8'($urandom_range(0, 255));
                        ALPHA_EDGE: begin
                            case ($urandom_range(0, 3))
                                0:       pb = 8'h00;
                                1:       pb = 8'hFF;
                                2:       pb = 8'h20;
                                default: pb = 8'h1F;
                            endcase
                        end
                        default:       pb = ($urandom_range(0, 1) ? 8'h41 : 8'h61) +
                                            8'($urandom_range(0, 25));
                    endcase
                    word[b * 8 +: 8] = pb;
                end
                cfg_write(REG_PATTERN_FIRST + 3'(k), word);
            end
            cfg_write(lsf_pkg::REG_LENGTH, 64'(new_len));
            if ($urandom_range(0, 3) == 0)
                cfg_write(REG_SPARE, {$urandom, $urandom});

            if (phase == 2) begin
                // Keep the result side shut while beats keep coming, so the input backs up.
                tx_idle_on = 1'b0;
                @(posedge aclk);
                hold_start <= 1'b1;
                @(posedge aclk);
                hold_start <= 1'b0;
            end

            @(negedge aclk);
            target = queued_beats + $urandom_range(60, 120);
            k = queued_beats;
            while (queued_beats < target)
                queue_line(active_len());
            random_items += queued_beats - k;
            wait_idle();
        end

        wait_idle();
        repeat (4) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("line_substring_finder_top test passed");
        else
            $display("line_substring_finder_top test failed");
        $finish;
    end

endmodule
